// ===== design/bbdq_pkg.sv =====
// Shared types for the bounded byte deque: operation and status codes, cell control.
package bbdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_CLEAR      = 3'd4
    } bbdq_op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } bbdq_status_t;

    // Per-cycle command broadcast to every cell, one group per lane.
    // Lane A holds the queue front-first, lane B holds it rear-first.
    typedef struct packed {
        logic a_shr;   // shift toward higher cells, cell 0 takes the push byte
        logic a_shl;   // shift toward cell 0
        logic a_wr;    // write push byte into the cell whose index equals the count
        logic b_shr;
        logic b_shl;
        logic b_wr;
    } bbdq_ctrl_t;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 5;

endpackage

// ===== design/bbdq_cell.sv =====
// One deque cell: a front-ordered byte and a rear-ordered byte with neighbor shifting.
module bbdq_cell
    import bbdq_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 5
) (
    input  logic                aclk,
    input  bbdq_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [BYTE_W-1:0]   push_byte,
    input  logic [BYTE_W-1:0]   a_from_lo,
    input  logic [BYTE_W-1:0]   a_from_hi,
    input  logic [BYTE_W-1:0]   b_from_lo,
    input  logic [BYTE_W-1:0]   b_from_hi,
    output logic [BYTE_W-1:0]   a_q,
    output logic [BYTE_W-1:0]   b_q
);

    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic              hit;

    // Indexed write lands one past the last held byte.
    assign hit = (count == CNT_W'(CELL_INDEX));

    always_comb begin
        a_next = a_reg;
        if (ctrl.a_shr) begin
            a_next = a_from_lo;
        end else if (ctrl.a_shl) begin
            a_next = a_from_hi;
        end else if (ctrl.a_wr && hit) begin
            a_next = push_byte;
        end
    end

    always_comb begin
        b_next = b_reg;
        if (ctrl.b_shr) begin
            b_next = b_from_lo;
        end else if (ctrl.b_shl) begin
            b_next = b_from_hi;
        end else if (ctrl.b_wr && hit) begin
            b_next = push_byte;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_q = a_reg;
    assign b_q = b_reg;

endmodule

// ===== design/bounded_byte_deque.sv =====
// Top level of the bounded byte deque: cell row, count, capacity register, result register.
//
// A double-ended queue of up to DEPTH bytes built as a row of identical cells. Each cell
// holds two bytes: lane A keeps the queue front-first (front byte in cell 0) and lane B
// keeps it rear-first (rear byte in cell 0), so both ends are always read from cell 0 and
// no wide read mux exists. Pushing at one end shifts that end's lane by one cell and writes
// the byte into the other lane at the cell whose index equals the count; popping shifts
// the popped end's lane back. A new beat is accepted on every clock while the result
// register is empty or being drained, and its result beat appears on the m_ side the next
// cycle, so sustained rate is one beat per clock while m_ready stays high. The result
// register is the only thing that can hold off s_ready.
// capacity_limit (cfg_wr_en / cfg_wr_data, reset 16) caps the count; values above DEPTH
// act as DEPTH, and lowering it below the count keeps the held bytes. Push at the cap
// returns status full, pop from empty returns status empty with byte 0, clear drops all
// bytes, unused operation codes change nothing. fill_count is the count after the beat.
// Write capacity only while no beat is in flight.
module bounded_byte_deque
    import bbdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic [BYTE_W-1:0]   s_push_byte,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_pop_byte,
    output logic [1:0]          m_status,
    output logic [CAP_W-1:0]    m_fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Control state
    logic [CAP_W-1:0]  cap_limit_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg;

    // Result payload
    logic [BYTE_W-1:0] pop_byte_reg, pop_byte_next;
    logic [1:0]        status_reg;
    bbdq_status_t      status_next;
    logic [CAP_W-1:0]  fill_reg;

    logic              s_fire;
    bbdq_ctrl_t        ctrl;
    logic [CMP_W-1:0]  cap_ext, depth_ext, cap_use, cnt_ext;
    logic              room, any_held;

    logic [BYTE_W-1:0] a_q [DEPTH];
    logic [BYTE_W-1:0] b_q [DEPTH];

    // Result register frees up when empty or drained this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Capacity in use, saturated to DEPTH.
    assign cap_ext   = CMP_W'(cap_limit_reg);
    assign depth_ext = CMP_W'(DEPTH);
    assign cap_use   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign cnt_ext   = CMP_W'(count_reg);
    assign room      = cnt_ext < cap_use;
    assign any_held  = (count_reg != '0);

    // Decode: cell commands, new count and result fields.
    always_comb begin
        ctrl          = '0;
        count_next    = count_reg;
        pop_byte_next = '0;
        status_next   = ST_DONE;
        case (bbdq_op_t'(s_operation))
            OP_PUSH_FRONT: begin
                if (!room) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.a_shr = s_fire;
                    ctrl.b_wr  = s_fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_REAR: begin
                if (!room) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.a_wr  = s_fire;
                    ctrl.b_shr = s_fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (!any_held) begin
                    status_next = ST_EMPTY;
                end else begin
                    ctrl.a_shl    = s_fire;
                    pop_byte_next = a_q[0];
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            OP_POP_REAR: begin
                if (!any_held) begin
                    status_next = ST_EMPTY;
                end else begin
                    ctrl.b_shl    = s_fire;
                    pop_byte_next = b_q[0];
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                // unused codes: no change, done status
            end
        endcase
    end

    // Cell row. Lane ends: cell 0 shifts in the push byte, the top cell shifts in zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [BYTE_W-1:0] a_lo, a_hi, b_lo, b_hi;

        if (i == 0) begin : g_first
            assign a_lo = s_push_byte;
            assign b_lo = s_push_byte;
        end else begin : g_mid_lo
            assign a_lo = a_q[i-1];
            assign b_lo = b_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign a_hi = '0;
            assign b_hi = '0;
        end else begin : g_mid_hi
            assign a_hi = a_q[i+1];
            assign b_hi = b_q[i+1];
        end

        bbdq_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .push_byte (s_push_byte),
            .a_from_lo (a_lo),
            .a_from_hi (a_hi),
            .b_from_lo (b_lo),
            .b_from_hi (b_hi),
            .a_q       (a_q[i]),
            .b_q       (b_q[i])
        );
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_limit_reg <= CAP_W'(16);
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_limit_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                count_reg <= count_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pop_byte_reg <= pop_byte_next;
            status_reg   <= status_next;
            fill_reg     <= CAP_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pop_byte   = pop_byte_reg;
    assign m_status     = status_reg;
    assign m_fill_count = fill_reg;

endmodule

// ===== tb/tb_bounded_byte_deque.sv =====
// Self-checking testbench for bounded_byte_deque: scoreboard class, drivers, phases, checks.
`timescale 1ns / 100ps

module tb_bounded_byte_deque;
    import bbdq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CLK_PERIOD = 12;
    // Codes above OP_CLEAR are unused: the block must leave its state alone.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int N_PHASES   = 9;
    localparam int PHASE_BEATS = 200;

    // Mirror of the deque. The ring, both indices and the count follow every
    // accepted beat, and each beat leaves one expected result in a FIFO.
    class deque_scoreboard;
        typedef struct {
            bit [7:0]     pop_byte;
            bbdq_status_t status;
            bit [4:0]     fill;
        } deque_result_t;

        bit [7:0]      ring [DEPTH];
        int unsigned   head;
        int unsigned   tail;
        int unsigned   count;
        int unsigned   cap;
        deque_result_t awaited_q [$];
        int            errors;
        int            checked;
        int            full_seen;
        int            empty_seen;
        int unsigned   deepest;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            cap = DEPTH;
            errors = 0;
            checked = 0;
            full_seen = 0;
            empty_seen = 0;
            deepest = 0;
        endfunction

        function void set_capacity(bit [4:0] v);
            cap = (v > DEPTH) ? DEPTH : v;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // Accepted input beat: advance the mirror, queue its result.
        function void note_op(logic [2:0] op, logic [7:0] data);
            deque_result_t r;
            r.pop_byte = 8'd0;
            r.status = ST_DONE;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (count >= cap) begin
                        r.status = ST_FULL;
                    end else if (op == OP_PUSH_FRONT) begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = data;
                        count++;
                    end else begin
                        ring[tail] = data;
                        tail = (tail + 1) % DEPTH;
                        count++;
                    end
                end
                OP_POP_FRONT, OP_POP_REAR: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else if (op == OP_POP_FRONT) begin
                        r.pop_byte = ring[head];
                        head = (head + 1) % DEPTH;
                        count--;
                    end else begin
                        tail = (tail + DEPTH - 1) % DEPTH;
                        r.pop_byte = ring[tail];
                        count--;
                    end
                end
                OP_CLEAR: begin
                    head = 0;
                    tail = 0;
                    count = 0;
                end
                default: ;
            endcase
            r.fill = count[4:0];
            if (count > deepest)
                deepest = count;
            awaited_q.push_back(r);
        endfunction

        // Accepted result beat: compare against the oldest expectation.
        function void check_result(logic [7:0] pb, logic [1:0] st, logic [4:0] fc);
            deque_result_t r;
            if (awaited_q.size() == 0) begin
                $error("result beat with nothing expected: pop_byte %0d status %0d fill %0d",
                       pb, st, fc);
                errors++;
                return;
            end
            r = awaited_q.pop_front();
            checked++;
            if (r.status == ST_FULL)
                full_seen++;
            if (r.status == ST_EMPTY)
                empty_seen++;
            if (pb !== r.pop_byte) begin
                $error("pop_byte: expected %0d, got %0d", r.pop_byte, pb);
                errors++;
            end
            if (st !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (fc !== r.fill) begin
                $error("fill_count: expected %0d, got %0d", r.fill, fc);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CAP_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [2:0]          s_operation;
    logic [BYTE_W-1:0]   s_push_byte;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [BYTE_W-1:0]   m_pop_byte;
    logic [1:0]          m_status;
    logic [CAP_W-1:0]    m_fill_count;

    deque_scoreboard sb;
    bit  tx_calm;       // sender inserts no random gaps while set
    bit  rx_calm;       // receiver never stalls while set
    int  stall_left = 0;
    int  beats_sent;
    int  cap_writes;

    bounded_byte_deque #(.DEPTH(DEPTH)) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_push_byte  (s_push_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_byte   (m_pop_byte),
        .m_status     (m_status),
        .m_fill_count (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop. Slowest legal run is well under ~2.4 ms;
    // this is several times that.
    initial begin
        #10_000_000;
        $display("tb_bounded_byte_deque NOT OK");
        $finish;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Weighted operation pick: a few spare codes and clears, then pushes
    // at push_pct of the rest, pops otherwise.
    function automatic logic [2:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        if (r < 5)
            return OP_CLEAR;
        if (r < 5 + push_pct * 95 / 100)
            return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
    endfunction

    // Both handshakes are sampled here on pre-edge values; inputs are
    // noted before results, which is safe since each result is registered after its input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_op(s_operation, s_push_byte);
            if (m_valid && m_ready)
                sb.check_result(m_pop_byte, m_status, m_fill_count);
        end
    end

    // Receiver back-pressure: random stalls, off entirely while rx_calm.
    always @(posedge aclk) begin : rx_side
        int nap;
        if (rx_calm || !aresetn) begin
            m_ready <= !rx_calm ? 1'b0 : 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            nap = pick_gap();
            if (nap > 0) begin
                m_ready <= 1'b0;
                stall_left = nap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // One input beat. Called at a clock edge; returns at the edge where the
    // beat was accepted, with valid still high.
    task automatic send_beat(input logic [2:0] op, input logic [7:0] data);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_push_byte <= data;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Drop valid and hold off until every expected result is back.
    // Always waits on the clock before checking, so valid is not toggled twice in a step.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Capacity changes only with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain_results();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(v);
        cap_writes++;
    endtask

    task automatic run_phase(input int n, input int push_pct);
        for (int i = 0; i < n; i++) begin
            // occasional full pause mid-stream
            if ($urandom_range(149) == 0)
                drain_results();
            send_beat(pick_op(push_pct), 8'($urandom));
        end
    endtask

    initial begin
        // Phase table: capacity and push bias. Phase 1 lowers capacity
        // below what phase 0 left behind; 31 and 17 exercise saturation.
        int unsigned phase_cap [N_PHASES];
        int          phase_push [N_PHASES];
        phase_cap  = '{16, 3, 0, 31, 1, 17, 0, 16, 0};
        phase_push = '{75, 30, 50, 70, 50, 60, 55, 40, 55};
        phase_cap[6] = $urandom_range(15, 2);
        phase_cap[8] = $urandom_range(31, 0);

        sb          = new();
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        beats_sent  = 0;
        cap_writes  = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_operation = OP_CLEAR;
        s_push_byte = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pops, both-end pushes with extreme bytes, pops from
        // both ends, spare codes, clear, then capacity zero and capacity one.
        send_beat(OP_POP_FRONT, 8'h00);
        send_beat(OP_POP_REAR, 8'hFF);
        send_beat(OP_PUSH_FRONT, 8'h00);
        send_beat(OP_PUSH_REAR, 8'hFF);
        send_beat(OP_PUSH_FRONT, 8'hA5);
        send_beat(OP_PUSH_REAR, 8'h5A);
        send_beat(OP_POP_FRONT, 8'h00);
        send_beat(OP_POP_REAR, 8'h00);
        send_beat(OP_SPARE_FIRST, 8'h3C);
        send_beat(OP_SPARE_FIRST + 3'd1, 8'hC3);
        send_beat(OP_SPARE_LAST, 8'hFF);
        send_beat(OP_CLEAR, 8'h77);
        send_beat(OP_POP_FRONT, 8'h00);
        send_beat(OP_POP_REAR, 8'h00);

        write_capacity(5'd0);
        send_beat(OP_PUSH_FRONT, 8'h11);
        send_beat(OP_PUSH_REAR, 8'h22);

        write_capacity(5'd1);
        send_beat(OP_PUSH_REAR, 8'h80);
        send_beat(OP_PUSH_FRONT, 8'h01);
        send_beat(OP_POP_FRONT, 8'h00);
        send_beat(OP_POP_REAR, 8'h00);

        // Random phases; phase 3 runs with no random gaps or stalls on either side.
        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(phase_cap[p][CAP_W-1:0]);
            tx_calm = (p == 3);
            rx_calm = (p == 3);
            run_phase(PHASE_BEATS, phase_push[p]);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        drain_results();
        repeat (4) @(posedge aclk);

        $display("Run: %0d beats in, %0d results checked, %0d capacity writes, deepest fill %0d",
                 beats_sent, sb.checked, cap_writes, sb.deepest);
        $display("     %0d pushes refused as full, %0d pops refused as empty",
                 sb.full_seen, sb.empty_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_bounded_byte_deque OK");
        end else begin
            $display("tb_bounded_byte_deque NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bbdq_pkg.sv
design/bbdq_cell.sv
design/bounded_byte_deque.sv
tb/tb_bounded_byte_deque.sv
